@@ sv/xct_pkg.sv @@
// Shared types and codes for the XMODEM-style CRC transfer engine.
// Used by every module of the block and by its checker; depends on nothing.
package xct_pkg;

    localparam int CHUNK_BYTES_DEF = 128;
    localparam logic [7:0] MAX_RETRIES_RST = 8'd25;

    // Packet and reply kinds.
    localparam logic [2:0] C_SOH  = 3'd0;
    localparam logic [2:0] C_STX  = 3'd1;
    localparam logic [2:0] C_EOT  = 3'd2;
    localparam logic [2:0] C_ACK  = 3'd3;
    localparam logic [2:0] C_NAK  = 3'd4;
    localparam logic [2:0] C_CAN  = 3'd5;
    localparam logic [2:0] C_NONE = 3'd6;

    // Storage actions.
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_OPEN_WR   = 3'd1;
    localparam logic [2:0] ACT_OPEN_RD   = 3'd2;
    localparam logic [2:0] ACT_COMMIT    = 3'd3;
    localparam logic [2:0] ACT_CLOSE     = 3'd4;
    localparam logic [2:0] ACT_CLOSE_RM  = 3'd5;
    localparam logic [2:0] ACT_FETCH     = 3'd6;

    localparam int OP_PACKET = 0;
    localparam int OP_CHUNK  = 1;

    typedef struct packed {
        logic        op;
        logic [2:0]  control;
        logic [15:0] seq;
        logic [15:0] crc_in;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last;
        logic        name_ok;
        logic        store_ok;
        logic        gate_refuse;
    } t_item;

    typedef struct packed {
        logic [2:0]  reply_control;
        logic [15:0] reply_seq;
        logic [15:0] reply_crc;
        logic [7:0]  reply_length;
        logic [2:0]  storage_action;
        logic [15:0] chunk_index;
        logic        final_chunk;
    } t_result;

endpackage

@@ sv/xct_in_stage.sv @@
// Input register stage of the transfer engine: holds one accepted word
// until the decision core consumes it. Depends on xct_pkg.
module xct_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  xct_pkg::t_item  i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output xct_pkg::t_item  o_item
);

    logic           r_valid;
    xct_pkg::t_item r_item;

    // A word may enter when the stage is empty or its word leaves this cycle.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ sv/xct_core.sv @@
// Decision core of the transfer engine: CRC and byte count, transfer mode,
// sequence, retry budget and end mark, plus the reply decision. Depends on xct_pkg.
module xct_core #(
    parameter int CHUNK_BYTES = xct_pkg::CHUNK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    input  xct_pkg::t_item    i_item,
    input  logic              i_out_free,
    output logic              o_advance,
    output logic              o_has_result,
    output xct_pkg::t_result  o_result
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } t_mode;

    localparam logic [7:0] CHUNK_LEN = 8'(CHUNK_BYTES);

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = {c[7:0], c[15:8]} ^ {8'h00, b};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

    t_mode       r_mode, n_mode;
    logic        r_awaiting, n_awaiting;
    logic [15:0] r_pkt_num, n_pkt_num;
    logic [7:0]  r_retries, n_retries;
    logic        r_end_pend, n_end_pend;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_max_retries;

    logic        take;
    logic [15:0] crc_t;
    logic [7:0]  cnt_t;
    logic        short_chunk;
    logic        has_res;
    xct_pkg::t_result res;

    assign take  = i_item.byte_valid && (r_count < CHUNK_LEN);
    assign crc_t = take ? crc_byte(r_crc, i_item.data_byte) : r_crc;
    assign cnt_t = take ? r_count + 8'd1 : r_count;
    assign short_chunk = cnt_t < CHUNK_LEN;

    always_comb begin
        n_mode     = r_mode;
        n_awaiting = r_awaiting;
        n_pkt_num  = r_pkt_num;
        n_retries  = r_retries;
        n_end_pend = r_end_pend;
        n_crc      = r_crc;
        n_count    = r_count;
        has_res    = 1'b0;
        res        = '0;
        res.reply_control = xct_pkg::C_NONE;

        if (i_item.op == 1'(xct_pkg::OP_CHUNK)) begin
            if (r_awaiting) begin
                n_crc   = crc_t;
                n_count = cnt_t;
                if (i_item.last) begin
                    if (short_chunk) begin
                        n_end_pend = 1'b1;
                    end
                    has_res            = 1'b1;
                    res.reply_control  = xct_pkg::C_SOH;
                    res.reply_seq      = r_pkt_num;
                    res.reply_crc      = crc_t;
                    res.reply_length   = cnt_t;
                    res.final_chunk    = short_chunk;
                    n_awaiting         = 1'b0;
                    n_crc              = '0;
                    n_count            = '0;
                end
            end
        end else if (!r_awaiting) begin
            n_crc   = crc_t;
            n_count = cnt_t;
            if (i_item.last) begin
                n_crc   = '0;
                n_count = '0;
                has_res = 1'b1;
                if (i_item.gate_refuse) begin
                    res.reply_control = xct_pkg::C_NAK;
                end else begin
                    case (i_item.control)
                        xct_pkg::C_SOH, xct_pkg::C_STX: begin
                            if (i_item.seq == 16'd0 && r_mode == MODE_IDLE) begin
                                if (!i_item.name_ok || !i_item.store_ok) begin
                                    res.reply_control = xct_pkg::C_NAK;
                                end else begin
                                    n_pkt_num  = 16'd1;
                                    n_retries  = r_max_retries;
                                    n_end_pend = 1'b0;
                                    if (i_item.control == xct_pkg::C_SOH) begin
                                        n_mode = MODE_RX;
                                        res.reply_control  = xct_pkg::C_ACK;
                                        res.storage_action = xct_pkg::ACT_OPEN_WR;
                                    end else begin
                                        // Transmit start: open and fetch chunk zero.
                                        n_mode     = MODE_TX;
                                        n_awaiting = 1'b1;
                                        res.storage_action = xct_pkg::ACT_OPEN_RD;
                                        res.chunk_index    = 16'd0;
                                    end
                                end
                            end else if (r_mode == MODE_RX) begin
                                if (i_item.seq == r_pkt_num && crc_t == i_item.crc_in) begin
                                    if (!i_item.store_ok) begin
                                        n_mode = MODE_IDLE;
                                        res.reply_control  = xct_pkg::C_CAN;
                                        res.storage_action = xct_pkg::ACT_CLOSE_RM;
                                    end else begin
                                        n_pkt_num = r_pkt_num + 16'd1;
                                        res.reply_control  = xct_pkg::C_ACK;
                                        res.storage_action = xct_pkg::ACT_COMMIT;
                                    end
                                end else begin
                                    res.reply_control = xct_pkg::C_NAK;
                                end
                            end else if (r_mode == MODE_TX) begin
                                n_mode = MODE_IDLE;
                                res.reply_control  = xct_pkg::C_CAN;
                                res.storage_action = xct_pkg::ACT_CLOSE;
                            end else begin
                                // Data packet in idle mode that does not open a transfer.
                                has_res = 1'b0;
                            end
                        end
                        xct_pkg::C_EOT: begin
                            if (r_mode != MODE_RX) begin
                                res.reply_control = xct_pkg::C_NAK;
                            end else begin
                                n_mode = MODE_IDLE;
                                res.reply_control  = xct_pkg::C_ACK;
                                res.storage_action = xct_pkg::ACT_CLOSE;
                            end
                        end
                        xct_pkg::C_CAN: begin
                            res.reply_control  = xct_pkg::C_ACK;
                            res.storage_action = (r_mode == MODE_RX) ? xct_pkg::ACT_CLOSE_RM
                                                                     : xct_pkg::ACT_CLOSE;
                            n_mode     = MODE_IDLE;
                            n_end_pend = 1'b0;
                        end
                        xct_pkg::C_ACK: begin
                            if (r_mode != MODE_TX) begin
                                res.reply_control = xct_pkg::C_CAN;
                            end else if (r_end_pend) begin
                                n_mode     = MODE_IDLE;
                                n_end_pend = 1'b0;
                                res.reply_control  = xct_pkg::C_EOT;
                                res.storage_action = xct_pkg::ACT_CLOSE;
                            end else begin
                                n_retries  = r_max_retries;
                                n_pkt_num  = r_pkt_num + 16'd1;
                                n_awaiting = 1'b1;
                                res.storage_action = xct_pkg::ACT_FETCH;
                                res.chunk_index    = r_pkt_num;
                            end
                        end
                        xct_pkg::C_NAK: begin
                            if (r_mode != MODE_TX) begin
                                res.reply_control = xct_pkg::C_CAN;
                            end else if (r_retries <= 8'd1) begin
                                n_retries  = '0;
                                n_mode     = MODE_IDLE;
                                n_end_pend = 1'b0;
                                res.reply_control  = xct_pkg::C_CAN;
                                res.storage_action = xct_pkg::ACT_CLOSE;
                            end else begin
                                n_retries  = r_retries - 8'd1;
                                n_awaiting = 1'b1;
                                res.storage_action = xct_pkg::ACT_FETCH;
                                res.chunk_index    = r_pkt_num - 16'd1;
                            end
                        end
                        default: begin
                            has_res = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // The word moves on unless it has a result and the result register is full.
    assign o_advance    = i_valid && (i_out_free || !has_res);
    assign o_has_result = has_res;
    assign o_result     = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_awaiting    <= 1'b0;
            r_pkt_num     <= '0;
            r_retries     <= '0;
            r_end_pend    <= 1'b0;
            r_crc         <= '0;
            r_count       <= '0;
            r_max_retries <= xct_pkg::MAX_RETRIES_RST;
        end else begin
            if (i_cfg_valid) begin
                r_max_retries <= i_cfg_data;
            end
            if (o_advance) begin
                r_mode     <= n_mode;
                r_awaiting <= n_awaiting;
                r_pkt_num  <= n_pkt_num;
                r_retries  <= n_retries;
                r_end_pend <= n_end_pend;
                r_crc      <= n_crc;
                r_count    <= n_count;
            end
        end
    end

endmodule

@@ sv/xct_out_stage.sv @@
// Result register of the transfer engine: holds one reply word until the
// downstream side takes it. Depends on xct_pkg.
module xct_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  xct_pkg::t_result  i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output xct_pkg::t_result  o_result
);

    logic             r_valid;
    xct_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ sv/xmodem_crc_transfer_engine.sv @@
// XMODEM-style transfer engine with a CRC-16/XMODEM check (poly 0x1021, init 0).
// Top level: stream ports, input register, decision core and result register.
// Depends on xct_pkg, xct_in_stage, xct_core and xct_out_stage.
//
// The engine takes one word per clock cycle, back to back, as long as the result
// side keeps up; a word's reply is loaded into the result register from the input
// register through the decision core. The rate is set by the decision core, a
// combinational CRC byte update and reply decision between the two registers.
// Words that produce no result word never wait on the result side. The max_retries register
// resets to 25 and is written on the cfg channel, which is always ready; write it
// only while no transfer word is in flight.
module xmodem_crc_transfer_engine #(
    parameter int CHUNK_BYTES = xct_pkg::CHUNK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // seq[15:0], crc_in[31:16], data_byte[39:32], name_ok[40], store_ok[41],
    // gate_refuse[42], zero[47:43]
    input  logic [47:0] s_axis_tdata,
    // op[0], control[3:1], byte_valid[4]
    input  logic [4:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reply_seq[15:0], reply_crc[31:16], reply_length[39:32],
    // storage_action[42:40], chunk_index[58:43], zero[63:59]
    output logic [63:0] m_axis_tdata,
    // reply_control[2:0], final_chunk[3]
    output logic [3:0]  m_axis_tuser
);

    xct_pkg::t_item   in_item;
    xct_pkg::t_item   core_item;
    xct_pkg::t_result core_result;
    xct_pkg::t_result out_result;
    logic             core_valid;
    logic             advance;
    logic             has_result;
    logic             out_free;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_item.op          = s_axis_tuser[0];
        in_item.control     = s_axis_tuser[3:1];
        in_item.byte_valid  = s_axis_tuser[4];
        in_item.seq         = s_axis_tdata[15:0];
        in_item.crc_in      = s_axis_tdata[31:16];
        in_item.data_byte   = s_axis_tdata[39:32];
        in_item.name_ok     = s_axis_tdata[40];
        in_item.store_ok    = s_axis_tdata[41];
        in_item.gate_refuse = s_axis_tdata[42];
        in_item.last        = s_axis_tlast;
    end

    xct_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (core_valid),
        .o_item    (core_item)
    );

    xct_core #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (core_valid),
        .i_item       (core_item),
        .i_out_free   (out_free),
        .o_advance    (advance),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    xct_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {5'b00000, out_result.chunk_index, out_result.storage_action,
                           out_result.reply_length, out_result.reply_crc,
                           out_result.reply_seq};
    assign m_axis_tuser = {out_result.final_chunk, out_result.reply_control};

endmodule

@@ sv/xct_checker.sv @@
// Port-level checker for the transfer engine and its bind to the top level.
// Depends on xct_pkg and xmodem_crc_transfer_engine.
module xct_checker #(
    parameter int CHUNK_BYTES = xct_pkg::CHUNK_BYTES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    localparam logic [7:0] CHUNK_LEN = 8'(CHUNK_BYTES);

    // A reply waiting on the result side holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("reply word changed while stalled");

    // Only a data frame carries sequence, CRC, length and the final mark.
    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] != xct_pkg::C_SOH |->
            m_axis_tdata[39:0] == 40'd0 && !m_axis_tuser[3])
        else $error("frame fields set on a non-frame reply");

    // A data frame orders no storage action, fits a chunk and is marked final
    // exactly when it is short.
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == xct_pkg::C_SOH |->
            m_axis_tdata[58:40] == 19'd0 && m_axis_tdata[39:32] <= CHUNK_LEN &&
            m_axis_tuser[3] == (m_axis_tdata[39:32] < CHUNK_LEN))
        else $error("bad data frame");

    // A result without a reply is always a read open or a chunk fetch.
    a_fetch_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == xct_pkg::C_NONE |->
            m_axis_tdata[42:40] == xct_pkg::ACT_OPEN_RD ||
            m_axis_tdata[42:40] == xct_pkg::ACT_FETCH)
        else $error("silent result without a fetch");

endmodule

bind xmodem_crc_transfer_engine xct_checker #(
    .CHUNK_BYTES (CHUNK_BYTES)
) u_xct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
